FILE: sv/mrf_pkg.sv
// Shared types, codes and the CRC-16/MODBUS byte step for the Modbus RTU
// read master framer. No dependencies.
`default_nettype none

package mrf_pkg;

    // Input item selector codes
    localparam logic [1:0] FUNC_REQUEST = 2'd0;
    localparam logic [1:0] FUNC_RX_BYTE = 2'd1;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

    // Result kind codes
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Exchange status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADQ    = 2'd1;
    localparam logic [1:0] ST_CRC     = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    // Protocol constants
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  FC_READ_HOLD  = 8'h03;
    localparam logic [7:0]  RSP_OVERHEAD  = 8'd5;

    // Request byte positions within the transmit run
    localparam logic [2:0] REQ_ADDR     = 3'd0;
    localparam logic [2:0] REQ_FUNC     = 3'd1;
    localparam logic [2:0] REQ_START_HI = 3'd2;
    localparam logic [2:0] REQ_START_LO = 3'd3;
    localparam logic [2:0] REQ_QTY_HI   = 3'd4;
    localparam logic [2:0] REQ_QTY_LO   = 3'd5;
    localparam logic [2:0] REQ_CRC_LO   = 3'd6;
    localparam logic [2:0] REQ_CRC_HI   = 3'd7;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] start_address;
        logic [15:0] quantity;
        logic [7:0]  rx_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [15:0] word_value;
        logic [6:0]  word_index;
        logic [1:0]  status;
        logic        last;
    } t_result;

    // Core to output stage: one single result or the start of a request run
    typedef struct packed {
        logic        res_valid;
        t_result     res;
        logic        run_start;
        logic [7:0]  dev_addr;
        logic [15:0] start_address;
        logic [15:0] quantity;
    } t_emit;

    // Output stage to core
    typedef struct packed {
        logic run_busy;
        logic out_free;
    } t_out_stat;

    // One byte of CRC-16/MODBUS, reflected, eight shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/mrf_core.sv
// Exchange state of the framer: response CRC, byte count, word assembly.
// Depends on mrf_pkg.
`default_nettype none

module mrf_core #(
    parameter int MAX_REGISTERS = 125
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_item_valid,
    input  wire mrf_pkg::t_item     i_item,
    input  wire logic [7:0]         i_dev_addr,
    input  wire mrf_pkg::t_out_stat i_out_stat,
    output logic                    o_consume,
    output mrf_pkg::t_emit          o_emit
);

    logic [15:0] r_crc_accum, n_crc_accum;
    logic [7:0]  r_rx_count, n_rx_count;
    logic [7:0]  r_exp_len, n_exp_len;
    logic        r_awaiting, n_awaiting;
    logic [6:0]  r_word_counter, n_word_counter;
    logic [7:0]  r_pending_hi;

    logic        w_store_hi;
    logic        w_needs_out;
    logic        w_res;
    logic        w_run;
    logic [1:0]  w_kind;
    logic [1:0]  w_status;
    logic [15:0] w_crc_next;
    logic [8:0]  w_pos;
    logic        w_qty_bad;

    // Decode the held item and work out the next exchange state
    always_comb begin
        n_crc_accum    = r_crc_accum;
        n_rx_count     = r_rx_count;
        n_exp_len      = r_exp_len;
        n_awaiting     = r_awaiting;
        n_word_counter = r_word_counter;
        w_store_hi     = 1'b0;
        w_res          = 1'b0;
        w_run          = 1'b0;
        w_kind         = mrf_pkg::KIND_STATUS;
        w_status       = mrf_pkg::ST_OK;
        w_crc_next     = mrf_pkg::crc16_byte(r_crc_accum, i_item.rx_byte);
        w_pos          = {1'b0, r_rx_count};
        w_qty_bad      = (i_item.quantity == 16'd0) ||
                         (i_item.quantity > 16'(MAX_REGISTERS));

        unique case (i_item.func)
            mrf_pkg::FUNC_REQUEST: begin
                n_awaiting = 1'b0;
                if (w_qty_bad) begin
                    w_res    = 1'b1;
                    w_status = mrf_pkg::ST_BADQ;
                end else begin
                    w_run          = 1'b1;
                    n_crc_accum    = mrf_pkg::CRC_INIT;
                    n_rx_count     = 8'd0;
                    n_exp_len      = {i_item.quantity[6:0], 1'b0} + mrf_pkg::RSP_OVERHEAD;
                    n_word_counter = 7'd0;
                    n_awaiting     = 1'b1;
                end
            end
            mrf_pkg::FUNC_RX_BYTE: begin
                if (r_awaiting) begin
                    n_crc_accum = w_crc_next;
                    n_rx_count  = r_rx_count + 8'd1;
                    if ((w_pos + 9'd1) >= {1'b0, r_exp_len}) begin
                        n_awaiting = 1'b0;
                        w_res      = 1'b1;
                        w_status   = (w_crc_next == 16'd0) ? mrf_pkg::ST_OK
                                                           : mrf_pkg::ST_CRC;
                    end else if (w_pos >= 9'd3 &&
                                 (w_pos + 9'd2) < {1'b0, r_exp_len}) begin
                        // odd positions carry the high byte of a word
                        if (w_pos[0]) begin
                            w_store_hi = 1'b1;
                        end else begin
                            w_res          = 1'b1;
                            w_kind         = mrf_pkg::KIND_WORD;
                            n_word_counter = r_word_counter + 7'd1;
                        end
                    end
                end
            end
            mrf_pkg::FUNC_TIMEOUT: begin
                if (r_awaiting) begin
                    n_awaiting = 1'b0;
                    w_res      = 1'b1;
                    w_status   = mrf_pkg::ST_TIMEOUT;
                end
            end
            default: begin
            end
        endcase
    end

    // Take the item only when no request run is busy and its result has a place to go
    assign w_needs_out = w_res;
    assign o_consume   = i_item_valid && !i_out_stat.run_busy &&
                         (!w_needs_out || i_out_stat.out_free);

    // Build the result or request run for the output stage
    always_comb begin
        o_emit                = '0;
        o_emit.res_valid      = o_consume && w_res;
        o_emit.res.kind       = w_kind;
        o_emit.res.last       = 1'b1;
        o_emit.res.status     = (w_kind == mrf_pkg::KIND_STATUS) ? w_status : 2'd0;
        if (w_kind == mrf_pkg::KIND_WORD) begin
            o_emit.res.word_value = {r_pending_hi, i_item.rx_byte};
            o_emit.res.word_index = r_word_counter;
        end
        o_emit.run_start      = o_consume && w_run;
        o_emit.dev_addr       = i_dev_addr;
        o_emit.start_address  = i_item.start_address;
        o_emit.quantity       = i_item.quantity;
    end

    // Advance exchange state on each consumed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_accum    <= mrf_pkg::CRC_INIT;
            r_rx_count     <= 8'd0;
            r_exp_len      <= 8'd0;
            r_awaiting     <= 1'b0;
            r_word_counter <= 7'd0;
        end else if (o_consume) begin
            r_crc_accum    <= n_crc_accum;
            r_rx_count     <= n_rx_count;
            r_exp_len      <= n_exp_len;
            r_awaiting     <= n_awaiting;
            r_word_counter <= n_word_counter;
        end
    end

    // Hold the high byte of the word being assembled
    always_ff @(posedge i_clk) begin
        if (o_consume && w_store_hi) begin
            r_pending_hi <= i_item.rx_byte;
        end
    end

    a_await_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awaiting |-> (r_rx_count < r_exp_len))
        else $error("receive count ran past expected length");

    a_await_min_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awaiting |-> (r_exp_len >= 8'd7))
        else $error("awaiting a response shorter than one word");

endmodule

`default_nettype wire

FILE: sv/mrf_out.sv
// Output stage: result register and the eight-byte request run, one byte per cycle
// while the result register is free, with its CRC step. Depends on mrf_pkg.
`default_nettype none

module mrf_out (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mrf_pkg::t_emit  i_emit,
    input  wire logic            i_tready,
    output mrf_pkg::t_out_stat   o_stat,
    output logic                 o_valid,
    output mrf_pkg::t_result     o_result
);

    logic             r_out_valid;
    mrf_pkg::t_result r_out;
    logic             r_run_active;
    logic [2:0]       r_run_cnt;
    logic [15:0]      r_tx_crc;
    logic [7:0]       r_dev_addr;
    logic [15:0]      r_start;
    logic [15:0]      r_qty;

    logic             w_out_free;
    logic             w_run_fire;
    logic [7:0]       w_run_byte;
    mrf_pkg::t_result w_run_res;

    assign w_out_free = !r_out_valid || i_tready;
    assign w_run_fire = r_run_active && w_out_free;

    // Select the request byte at the current run position
    always_comb begin
        unique case (r_run_cnt)
            mrf_pkg::REQ_ADDR:     w_run_byte = r_dev_addr;
            mrf_pkg::REQ_FUNC:     w_run_byte = mrf_pkg::FC_READ_HOLD;
            mrf_pkg::REQ_START_HI: w_run_byte = r_start[15:8];
            mrf_pkg::REQ_START_LO: w_run_byte = r_start[7:0];
            mrf_pkg::REQ_QTY_HI:   w_run_byte = r_qty[15:8];
            mrf_pkg::REQ_QTY_LO:   w_run_byte = r_qty[7:0];
            mrf_pkg::REQ_CRC_LO:   w_run_byte = r_tx_crc[7:0];
            mrf_pkg::REQ_CRC_HI:   w_run_byte = r_tx_crc[15:8];
            default:               w_run_byte = 8'h00;
        endcase
        w_run_res         = '0;
        w_run_res.kind    = mrf_pkg::KIND_TX;
        w_run_res.tx_byte = w_run_byte;
        w_run_res.last    = (r_run_cnt == mrf_pkg::REQ_CRC_HI);
    end

    // Sequence the request run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_active <= 1'b0;
            r_run_cnt    <= 3'd0;
        end else if (i_emit.run_start) begin
            r_run_active <= 1'b1;
            r_run_cnt    <= mrf_pkg::REQ_ADDR;
        end else if (w_run_fire) begin
            r_run_cnt <= r_run_cnt + 3'd1;
            if (r_run_cnt == mrf_pkg::REQ_CRC_HI) begin
                r_run_active <= 1'b0;
            end
        end
    end

    // Hold request fields, and fold header bytes into the running transmit CRC
    always_ff @(posedge i_clk) begin
        if (i_emit.run_start) begin
            r_dev_addr <= i_emit.dev_addr;
            r_start    <= i_emit.start_address;
            r_qty      <= i_emit.quantity;
            r_tx_crc   <= mrf_pkg::CRC_INIT;
        end else if (w_run_fire && r_run_cnt < mrf_pkg::REQ_CRC_LO) begin
            r_tx_crc <= mrf_pkg::crc16_byte(r_tx_crc, w_run_byte);
        end
    end

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_emit.res_valid || w_run_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (i_emit.res_valid) begin
            r_out <= i_emit.res;
        end else if (w_run_fire) begin
            r_out <= w_run_res;
        end
    end

    assign o_stat.run_busy = r_run_active;
    assign o_stat.out_free = w_out_free;
    assign o_valid         = r_out_valid;
    assign o_result        = r_out;

    a_no_res_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_emit.res_valid |-> !r_run_active)
        else $error("single result issued during request run");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_emit.res_valid |-> w_out_free)
        else $error("result register overwritten while full");

    a_run_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_emit.run_start |-> !r_run_active)
        else $error("request run restarted while active");

endmodule

`default_nettype wire

FILE: sv/modbus_rtu_read_master_framer.sv
// Timing: an item waits in the input register until consumed; its result then loads
// into the output register; a good request starts a run whose bytes pass through it.
// Throughput: one item per cycle for bytes and timeouts while no run is busy and the
// output register is free; a good request blocks the next item while its 8 bytes
// leave, one per cycle while the output register is free, via the CRC step.
// Reset: synchronous active low; clears control state, device address to 1.
`default_nettype none

module modbus_rtu_read_master_framer #(
    parameter int MAX_REGISTERS = 125
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,      // device_address
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,     // start_address[15:0], quantity[31:16],
                                               // rx_byte[39:32]
    input  wire logic [1:0]  s_axis_tuser,     // func[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,     // tx_byte[7:0], word_value[23:8],
                                               // word_index[30:24], status[32:31], zero
    output logic [1:0]       m_axis_tuser,     // kind[1:0]
    output logic             m_axis_tlast      // last
);

    logic               r_in_valid;
    mrf_pkg::t_item     r_in;
    logic [7:0]         r_dev_addr;
    logic               w_consume;
    mrf_pkg::t_emit     w_emit;
    mrf_pkg::t_out_stat w_out_stat;
    logic               w_out_valid;
    mrf_pkg::t_result   w_out;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= 8'd1;
        end else if (i_cfg_we) begin
            r_dev_addr <= i_cfg_wdata;
        end
    end

    // Input register: refill when empty or drained this cycle
    assign s_axis_tready = !r_in_valid || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.func          <= s_axis_tuser;
            r_in.start_address <= s_axis_tdata[15:0];
            r_in.quantity      <= s_axis_tdata[31:16];
            r_in.rx_byte       <= s_axis_tdata[39:32];
        end
    end

    mrf_core #(
        .MAX_REGISTERS (MAX_REGISTERS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_item       (r_in),
        .i_dev_addr   (r_dev_addr),
        .i_out_stat   (w_out_stat),
        .o_consume    (w_consume),
        .o_emit       (w_emit)
    );

    mrf_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_emit   (w_emit),
        .i_tready (m_axis_tready),
        .o_stat   (w_out_stat),
        .o_valid  (w_out_valid),
        .o_result (w_out)
    );

    // Pack the result item onto the stream
    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {7'd0, w_out.status, w_out.word_index, w_out.word_value,
                            w_out.tx_byte};
    assign m_axis_tuser  = w_out.kind;
    assign m_axis_tlast  = w_out.last;

endmodule

`default_nettype wire

FILE: verif/modbus_rtu_read_master_framer_tb.sv
// Self-checking bench for the Modbus RTU read-holding-registers master framer.
// Streams request, response-byte and timeout items against a built-in model of
// the exchange; depends on mrf_pkg and modbus_rtu_read_master_framer.
`timescale 1ns / 100ps

module modbus_rtu_read_master_framer_tb;

    localparam int          MAX_QTY       = 125;
    localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          QUIET_LIMIT   = 1000;

    typedef enum int {SRC_STEADY, SRC_BURSTY, SRC_CHOPPY} t_src_mode;
    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PATTERN, SINK_LONG} t_sink_mode;

    typedef struct {
        mrf_pkg::t_item item;
        bit             hold;
    } t_queued_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // start_address[15:0], quantity[31:16], rx_byte[39:32]
    logic [1:0]  s_axis_tuser = '0;   // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // tx_byte[7:0], word_value[23:8], word_index[30:24],
                                      // status[32:31], zero
    logic [1:0]  m_axis_tuser;        // kind[1:0]
    logic        m_axis_tlast;        // last

    // Stimulus and expectation stores
    t_queued_item     items_to_send[$];
    mrf_pkg::t_result results_due[$];
    bit               hold_next = 1'b0;
    int               mismatches = 0;

    t_src_mode    sender_mode = SRC_STEADY;
    t_sink_mode   sink_mode = SINK_OPEN;

    // Model state of the exchange, reset values
    logic [7:0]   dev_addr = 8'd1;
    logic [15:0]  rsp_crc = mrf_pkg::CRC_INIT;
    logic [7:0]   rsp_count = '0;
    logic [7:0]   rsp_len = '0;
    bit           awaiting_rsp = 1'b0;
    logic [7:0]   word_hi = '0;
    logic [6:0]   word_num = '0;

    modbus_rtu_read_master_framer uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Bitwise CRC-16/MODBUS: feed data bits LSB first into the reflected register
    function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] r;
        r = acc;
        for (int n = 0; n < 8; n++) begin
            if (r[0] ^ data[n]) begin
                r = (r >> 1) ^ mrf_pkg::CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic void push_status(input logic [1:0] st);
        mrf_pkg::t_result r;
        r = '0;
        r.kind   = mrf_pkg::KIND_STATUS;
        r.status = st;
        r.last   = 1'b1;
        results_due.push_back(r);
    endfunction

    // Advance the exchange model by one accepted item and queue what it yields
    task automatic advance_exchange(input mrf_pkg::t_item it);
        mrf_pkg::t_result r;
        logic [7:0]       req [8];
        logic [15:0]      crc;
        int               pos;
        case (it.func)
            mrf_pkg::FUNC_REQUEST: begin
                awaiting_rsp = 1'b0;
                if (it.quantity == 0 || it.quantity > MAX_QTY) begin
                    push_status(mrf_pkg::ST_BADQ);
                end else begin
                    req[0] = dev_addr;
                    req[1] = mrf_pkg::FC_READ_HOLD;
                    req[2] = it.start_address[15:8];
                    req[3] = it.start_address[7:0];
                    req[4] = it.quantity[15:8];
                    req[5] = it.quantity[7:0];
                    crc = mrf_pkg::CRC_INIT;
                    for (int i = 0; i < 6; i++) crc = crc_next(crc, req[i]);
                    req[6] = crc[7:0];
                    req[7] = crc[15:8];
                    for (int i = 0; i < 8; i++) begin
                        r = '0;
                        r.kind    = mrf_pkg::KIND_TX;
                        r.tx_byte = req[i];
                        r.last    = (i == 7);
                        results_due.push_back(r);
                    end
                    rsp_crc      = mrf_pkg::CRC_INIT;
                    rsp_count    = '0;
                    rsp_len      = 8'(5 + 2 * it.quantity);
                    word_num     = '0;
                    awaiting_rsp = 1'b1;
                end
            end
            mrf_pkg::FUNC_RX_BYTE: begin
                if (awaiting_rsp) begin
                    pos       = rsp_count;
                    rsp_crc   = crc_next(rsp_crc, it.rx_byte);
                    rsp_count = rsp_count + 8'd1;
                    if (pos + 1 >= rsp_len) begin
                        awaiting_rsp = 1'b0;
                        push_status((rsp_crc == 16'h0000) ? mrf_pkg::ST_OK : mrf_pkg::ST_CRC);
                    end else if (pos >= 3 && pos + 2 < rsp_len) begin
                        if (((pos - 3) % 2) == 0) begin
                            word_hi = it.rx_byte;
                        end else begin
                            r = '0;
                            r.kind       = mrf_pkg::KIND_WORD;
                            r.word_value = {word_hi, it.rx_byte};
                            r.word_index = word_num;
                            r.last       = 1'b1;
                            results_due.push_back(r);
                            word_num = word_num + 7'd1;
                        end
                    end
                end
            end
            mrf_pkg::FUNC_TIMEOUT: begin
                if (awaiting_rsp) begin
                    awaiting_rsp = 1'b0;
                    push_status(mrf_pkg::ST_TIMEOUT);
                end
            end
            default: ;
        endcase
    endtask

    function automatic int pick_burst();
        case (sender_mode)
            SRC_BURSTY: return $urandom_range(1, 12);
            SRC_CHOPPY: return $urandom_range(1, 3);
            default:    return 1000;
        endcase
    endfunction

    function automatic int pick_gap();
        case (sender_mode)
            SRC_BURSTY: return $urandom_range(1, 5);
            SRC_CHOPPY: return $urandom_range(0, 10);
            default:    return 0;
        endcase
    endfunction

    // Input driver: present queued items in bursts, predict at each accept
    mrf_pkg::t_item sent_item;
    int             burst_left = 0;
    int             gap_left = 0;

    always @(posedge i_clk) begin
        t_queued_item q;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                advance_exchange(sent_item);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (items_to_send.size() > 0 &&
                             !(items_to_send[0].hold && results_due.size() > 0)) begin
                    q = items_to_send.pop_front();
                    sent_item     = q.item;
                    s_axis_tdata  <= {q.item.rx_byte, q.item.quantity, q.item.start_address};
                    s_axis_tuser  <= q.item.func;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = pick_burst();
                        gap_left   = pick_gap();
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    // Output monitor: compare each accepted result, then pick next ready
    int sink_cycle = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin
        mrf_pkg::t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    $error("unexpected result: kind 0x%0h, data 0x%0h",
                           m_axis_tuser, m_axis_tdata);
                end else begin
                    want = results_due.pop_front();
                    check_field("kind", want.kind, m_axis_tuser);
                    check_field("tx_byte", want.tx_byte, m_axis_tdata[7:0]);
                    check_field("word_value", want.word_value, m_axis_tdata[23:8]);
                    check_field("word_index", want.word_index, m_axis_tdata[30:24]);
                    check_field("status", want.status, m_axis_tdata[32:31]);
                    check_field("padding", 0, m_axis_tdata[39:33]);
                    check_field("last", want.last, m_axis_tlast);
                end
            end
            sink_cycle++;
            case (sink_mode)
                SINK_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
                SINK_PATTERN: m_axis_tready <= ((sink_cycle % 7) >= 3);
                SINK_LONG: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_axis_tready <= 1'b0;
                    end else if ($urandom_range(0, 5) == 0) begin
                        stall_left = $urandom_range(1, 8);
                        m_axis_tready <= 1'b0;
                    end else begin
                        m_axis_tready <= 1'b1;
                    end
                end
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    // Watchdog: end the run if nothing moves for too long
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("modbus_rtu_read_master_framer test failed");
                $finish;
            end
        end
    end

    task automatic push_item(input logic [1:0] f, input logic [15:0] addr,
                             input logic [15:0] qty, input logic [7:0] rx);
        t_queued_item q;
        q.item.func          = f;
        q.item.start_address = addr;
        q.item.quantity      = qty;
        q.item.rx_byte       = rx;
        q.hold               = hold_next;
        hold_next            = 1'b0;
        items_to_send.push_back(q);
    endtask

    task automatic push_request(input logic [15:0] addr, input int qty);
        push_item(mrf_pkg::FUNC_REQUEST, addr, 16'(qty), 8'($urandom));
    endtask

    // Queue the first n_send bytes of a response frame for qty registers
    task automatic push_response(input int qty, input bit corrupt, input int n_send);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        int          pick;
        frame.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : dev_addr);
        frame.push_back(mrf_pkg::FC_READ_HOLD);
        frame.push_back(8'(2 * qty));
        for (int i = 0; i < 2 * qty; i++) frame.push_back(8'($urandom));
        crc = mrf_pkg::CRC_INIT;
        foreach (frame[i]) crc = crc_next(crc, frame[i]);
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);
        // Flip one bit anywhere so the residue cannot be zero
        if (corrupt) begin
            pick = $urandom_range(0, frame.size() - 1);
            frame[pick] = frame[pick] ^ (8'd1 << $urandom_range(0, 7));
        end
        for (int i = 0; i < n_send; i++)
            push_item(mrf_pkg::FUNC_RX_BYTE, 16'($urandom), 16'($urandom), frame[i]);
    endtask

    function automatic int pick_qty();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 16);
        return $urandom_range(17, MAX_QTY);
    endfunction

    function automatic int bad_qty();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_QTY + 1, 65535);
    endfunction

    // One random exchange; n counts the items the block acts on
    task automatic add_exchange(output int n);
        int pick, qty, k;
        n    = 0;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 24) == 0) hold_next = 1'b1;
        if (pick < 60) begin
            qty = pick_qty();
            push_request(16'($urandom), qty);
            push_response(qty, $urandom_range(0, 9) == 0, 5 + 2 * qty);
            n = 6 + 2 * qty;
        end else if (pick < 72) begin
            // Short frame closed by a timeout
            qty = pick_qty();
            k   = $urandom_range(0, 4 + 2 * qty);
            push_request(16'($urandom), qty);
            push_response(qty, 1'b0, k);
            push_item(mrf_pkg::FUNC_TIMEOUT, 16'($urandom), 16'($urandom), 8'($urandom));
            n = k + 2;
        end else if (pick < 80) begin
            // Short frame abandoned by a new request
            qty = pick_qty();
            k   = $urandom_range(0, 4 + 2 * qty);
            push_request(16'($urandom), qty);
            push_response(qty, 1'b0, k);
            n = k + 1;
            if ($urandom_range(0, 2) == 0) begin
                push_request(16'($urandom), bad_qty());
                n++;
            end else begin
                qty = pick_qty();
                push_request(16'($urandom), qty);
                push_response(qty, 1'b0, 5 + 2 * qty);
                n += 6 + 2 * qty;
            end
        end else if (pick < 88) begin
            push_request(16'($urandom), bad_qty());
            n = 1;
        end else begin
            // Noise while idle: stray bytes, timeouts, unused selector
            k = $urandom_range(1, 4);
            repeat (k) begin
                case ($urandom_range(0, 2))
                    0: push_item(mrf_pkg::FUNC_RX_BYTE, 16'($urandom), 16'($urandom),
                                 8'($urandom));
                    1: push_item(mrf_pkg::FUNC_TIMEOUT, 16'($urandom), 16'($urandom),
                                 8'($urandom));
                    default: push_item(FUNC_UNUSED, 16'($urandom), 16'($urandom),
                                       8'($urandom));
                endcase
            end
            n = k;
        end
    endtask

    task automatic write_device_address(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        dev_addr     = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Wait until all items are taken and every result is back, then settle
    task automatic wait_drained();
        do @(posedge i_clk);
        while (items_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int         counted, n, target;
        logic [7:0] dev;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset address, idle items, bad quantities, abandon, good frame, timeout
        sender_mode = SRC_STEADY;
        sink_mode   = SINK_LONG;
        push_item(mrf_pkg::FUNC_RX_BYTE, 16'h0000, 16'h0000, 8'hFF);
        push_item(mrf_pkg::FUNC_TIMEOUT, 16'h0000, 16'h0000, 8'h00);
        push_item(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF);
        push_request(16'h0000, 0);
        push_request(16'hFFFF, MAX_QTY + 1);
        push_request(16'hFFFF, 65535);
        push_request(16'h1234, 3);
        push_response(3, 1'b0, 1);
        push_request(16'h0000, 1);
        push_response(1, 1'b0, 7);
        push_request(16'hFFFF, MAX_QTY);
        push_response(MAX_QTY, 1'b0, 2);
        push_item(mrf_pkg::FUNC_TIMEOUT, 16'hFFFF, 16'hFFFF, 8'h00);
        wait_drained();

        // Random phases, each with its own address and flow pattern
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    dev = 8'h00; sender_mode = SRC_BURSTY; sink_mode = SINK_RANDOM;
                end
                1: begin
                    dev = 8'hFF; sender_mode = SRC_CHOPPY; sink_mode = SINK_PATTERN;
                end
                2: begin
                    dev = 8'($urandom); sender_mode = SRC_STEADY; sink_mode = SINK_OPEN;
                end
                default: begin
                    dev = 8'($urandom); sender_mode = SRC_BURSTY; sink_mode = SINK_LONG;
                end
            endcase
            write_device_address(dev);
            counted = 0;
            target  = 15;
            if (ph == 1) hold_next = 1'b1;
            // Full-size exchange reaches the top word index
            if (ph == 3) begin
                hold_next = 1'b1;
                push_request(16'($urandom), MAX_QTY);
                push_response(MAX_QTY, 1'b0, 5 + 2 * MAX_QTY);
                target = 5;
            end
            while (counted < target) begin
                add_exchange(n);
                counted += n;
            end
            wait_drained();
        end

        if (mismatches == 0 && results_due.size() == 0) begin
            $display("modbus_rtu_read_master_framer test passed");
        end else begin
            $display("modbus_rtu_read_master_framer test failed");
        end
        $finish;
    end

endmodule
